// ===== rtl/integer_square_root_core_macros.svh =====
// ----------------------------------------------------------------------------
// integer square root core: assertion macros
// shared property shapes for the checker files
// ----------------------------------------------------------------------------
`ifndef INTEGER_SQUARE_ROOT_CORE_MACROS_SVH
`define INTEGER_SQUARE_ROOT_CORE_MACROS_SVH

// same-cycle implication, quiet during reset
`define ISR_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("isr assertion failed");

// next-cycle implication, quiet during reset
`define ISR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("isr assertion failed");

`endif

// ===== rtl/isr_pkg.sv =====
// ----------------------------------------------------------------------------
// isr_pkg
// types and constants shared by the integer square root core
// ----------------------------------------------------------------------------
package isr_pkg;

   localparam int OPERAND_WIDTH = 64;
   localparam int ROOT_WIDTH    = 32;
   localparam int REM_WIDTH     = 34;
   localparam int COUNT_WIDTH   = 5;

   localparam logic [COUNT_WIDTH-1:0] LAST_STEP = COUNT_WIDTH'(ROOT_WIDTH - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ITERATE,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic start;
      logic step;
      logic load_out;
   } dp_cmd_type;

   typedef struct packed {
      logic last;
   } dp_status_type;

endpackage

// ===== rtl/integer_square_root_core.sv =====
// Steps: the idle state takes the operand, the iterate state settles one root bit per cycle,
// and the finish state hands the root to the output register, waiting there while a held
// result still occupies it. The core takes no new item until it is back in the idle state.
// A new item is taken while the previous result still waits in the output register.
// Reset: synchronous, active high; clears the controller state and rsp_valid.
// ----------------------------------------------------------------------------
// integer_square_root_core
// floor square root of a signed 64-bit operand, zero for nonpositive inputs
// ----------------------------------------------------------------------------
module integer_square_root_core (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  logic signed [isr_pkg::OPERAND_WIDTH-1:0] req_operand,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic [isr_pkg::ROOT_WIDTH-1:0]           rsp_root
);

   isr_pkg::dp_cmd_type    cmd;
   isr_pkg::dp_status_type status;

   isr_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   isr_datapath u_datapath (
      .clock       (clock),
      .req_operand (req_operand),
      .cmd         (cmd),
      .status      (status),
      .rsp_root    (rsp_root)
   );

endmodule

// ===== rtl/isr_datapath.sv =====
// ----------------------------------------------------------------------------
// isr_datapath
// digit-recurrence square root: one root bit per step, plus result register
// ----------------------------------------------------------------------------
module isr_datapath (
   input  logic                                clock,
   input  logic signed [isr_pkg::OPERAND_WIDTH-1:0] req_operand,
   input  isr_pkg::dp_cmd_type                 cmd,
   output isr_pkg::dp_status_type              status,
   output logic [isr_pkg::ROOT_WIDTH-1:0]      rsp_root
);

   logic [isr_pkg::OPERAND_WIDTH-1:0] radicand_ff, radicand_in;
   logic [isr_pkg::REM_WIDTH-1:0]     rem_ff, rem_in;
   logic [isr_pkg::ROOT_WIDTH-1:0]    root_ff, root_in;
   logic [isr_pkg::COUNT_WIDTH-1:0]   count_ff, count_in;
   logic [isr_pkg::ROOT_WIDTH-1:0]    rsp_root_ff, rsp_root_in;

   logic [isr_pkg::REM_WIDTH+1:0] rem_shift;
   logic [isr_pkg::REM_WIDTH+1:0] trial;
   logic [isr_pkg::REM_WIDTH+1:0] diff;
   logic                          fits;

   // bring down the next bit pair and try root*4+1
   assign rem_shift = {rem_ff, radicand_ff[isr_pkg::OPERAND_WIDTH-1 -: 2]};
   assign trial     = {2'b00, root_ff, 2'b01};
   assign fits      = (rem_shift >= trial);
   assign diff      = rem_shift - trial;

   always_comb begin
      radicand_in = radicand_ff;
      rem_in      = rem_ff;
      root_in     = root_ff;
      count_in    = count_ff;
      rsp_root_in = rsp_root_ff;
      if (cmd.start) begin
         // negative operands give a root of zero
         radicand_in = req_operand[isr_pkg::OPERAND_WIDTH-1] ? '0 : req_operand;
         rem_in      = '0;
         root_in     = '0;
         count_in    = isr_pkg::LAST_STEP;
      end else if (cmd.step) begin
         radicand_in = {radicand_ff[isr_pkg::OPERAND_WIDTH-3:0], 2'b00};
         rem_in      = fits ? diff[isr_pkg::REM_WIDTH-1:0]
                            : rem_shift[isr_pkg::REM_WIDTH-1:0];
         root_in     = {root_ff[isr_pkg::ROOT_WIDTH-2:0], fits};
         count_in    = count_ff - 1'b1;
      end
      if (cmd.load_out) begin
         rsp_root_in = root_ff;
      end
   end

   always_ff @(posedge clock) begin
      radicand_ff <= radicand_in;
      rem_ff      <= rem_in;
      root_ff     <= root_in;
      count_ff    <= count_in;
      rsp_root_ff <= rsp_root_in;
   end

   assign status.last = (count_ff == '0);
   assign rsp_root    = rsp_root_ff;

endmodule

// ===== rtl/isr_controller.sv =====
// ----------------------------------------------------------------------------
// isr_controller
// sequences the recurrence and owns both handshakes
// ----------------------------------------------------------------------------
module isr_controller (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output isr_pkg::dp_cmd_type    cmd,
   input  isr_pkg::dp_status_type status
);

   isr_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               out_free;

   // output register is free when empty or being emptied this cycle
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= isr_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_stall    = 1'b1;
      case (state_ff)
         isr_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = isr_pkg::ST_ITERATE;
            end
         end
         isr_pkg::ST_ITERATE: begin
            cmd.step = 1'b1;
            if (status.last) begin
               state_in = isr_pkg::ST_FINISH;
            end
         end
         isr_pkg::ST_FINISH: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               state_in     = isr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = isr_pkg::ST_IDLE;
         end
      endcase

      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== rtl/isr_checker.sv =====
// ----------------------------------------------------------------------------
// isr_checker
// port-level checks on the integer square root core
// ----------------------------------------------------------------------------
`include "integer_square_root_core_macros.svh"

module isr_checker (
   input logic                                     clock,
   input logic                                     reset,
   input logic                                     req_valid,
   input logic                                     req_stall,
   input logic signed [isr_pkg::OPERAND_WIDTH-1:0] req_operand,
   input logic                                     rsp_valid,
   input logic                                     rsp_stall,
   input logic [isr_pkg::ROOT_WIDTH-1:0]           rsp_root
);

   logic req_transfer;
   logic req_held;
   logic rsp_held;

   assign req_transfer = req_valid && !req_stall;
   assign req_held     = req_valid && req_stall;
   assign rsp_held     = rsp_valid && rsp_stall;

   // a held result stays offered
   `ISR_ASSERT_NEXT(a_rsp_valid_holds, clock, reset, rsp_held, rsp_valid)
   // a held result keeps its value
   `ISR_ASSERT_NEXT(a_rsp_root_holds, clock, reset, rsp_held, $stable(rsp_root))
   // once an operand is taken the core is busy with it
   `ISR_ASSERT_NEXT(a_busy_after_req, clock, reset, req_transfer, req_stall)
   // a stalled operand keeps its value
   `ISR_ASSERT_NEXT(a_req_operand_holds, clock, reset, req_held, $stable(req_operand))
   // largest root of a 63-bit operand
   `ISR_ASSERT_SAME(a_root_range, clock, reset, rsp_valid, (rsp_root <= 32'd3037000499))

endmodule

bind integer_square_root_core isr_checker u_isr_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .req_operand (req_operand),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_root    (rsp_root)
);
